// File: design/lcc_pkg.sv
// ----------------------------------------------------------------------------
// lcc_pkg
// Shared widths, constants and result codes for the Luhn card number checker.
// ----------------------------------------------------------------------------
`default_nettype none

package lcc_pkg;

  // input number and decimal digit layout
  localparam int IN_WIDTH       = 63;
  localparam int NUM_DIGITS     = 19;
  localparam int BCD_WIDTH      = 4 * NUM_DIGITS;

  // binary to decimal conversion: input bits consumed per pipeline stage
  localparam int BITS_PER_STAGE = 3;
  localparam int DD_STAGES      = (IN_WIDTH + BITS_PER_STAGE - 1) / BITS_PER_STAGE;

  // result field widths
  localparam int CFG_WIDTH      = 5;
  localparam int COUNT_WIDTH    = 5;
  localparam int SUM_WIDTH      = 8;

  // digit sum is reduced in groups before the final add
  localparam int GROUP_SIZE     = 5;
  localparam int NUM_GROUPS     = (NUM_DIGITS + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int GROUP_WIDTH    = 6;

  // register reset and parameter default
  localparam logic [CFG_WIDTH-1:0] MIN_DIGITS_RESET   = 5'd12;
  localparam int                   MAX_DIGITS_DEFAULT = 19;

  // reciprocal of ten scaled by 2**11, exact for quotients of 8-bit values
  localparam int              RECIP_SHIFT = 11;
  localparam logic [7:0]      RECIP_TEN   = 8'd205;

  // leading digit that marks a visa number
  localparam logic [3:0]      VISA_LEAD   = 4'd4;

  typedef enum logic [1:0] {
    VERDICT_INVALID    = 2'd0,
    VERDICT_VISA       = 2'd1,
    VERDICT_MASTERCARD = 2'd2
  } verdict_t;

endpackage

`default_nettype wire

// File: design/luhn_card_number_check_core.sv
// ----------------------------------------------------------------------------
// luhn_card_number_check_core
// Luhn mod 10 check of binary card numbers with digit count and card verdict.
// ----------------------------------------------------------------------------
// Accepts one card number per clock unless the pipeline holds, and returns one
// result per number, in order. The binary to decimal converter (21 stages, 3
// input bits each) is followed by three scoring stages: weighted digits with
// group sums and leading digit search, the total sum, and the mod 10 test
// with the verdict. The whole pipeline holds while a finished result waits on
// out_ready; in_ready follows that same hold.
// min_digits is written through cfg_we/cfg_wdata and resets to 12.
`default_nettype none

module luhn_card_number_check_core #(
  parameter int MAX_DIGITS = lcc_pkg::MAX_DIGITS_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // input transaction
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [lcc_pkg::IN_WIDTH-1:0]     card_number,
  // output transaction
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [1:0]                            verdict,
  output logic [lcc_pkg::COUNT_WIDTH-1:0]       digit_count,
  output logic [lcc_pkg::SUM_WIDTH-1:0]         luhn_sum,
  // configuration
  input  wire logic                             cfg_we,
  input  wire logic [lcc_pkg::CFG_WIDTH-1:0]    cfg_wdata
);

  localparam int CountW = lcc_pkg::COUNT_WIDTH;
  localparam int SumW   = lcc_pkg::SUM_WIDTH;
  localparam int GrpW   = lcc_pkg::GROUP_WIDTH;
  localparam int NGrp   = lcc_pkg::NUM_GROUPS;
  localparam int NDig   = lcc_pkg::NUM_DIGITS;

  logic                           en;
  logic [lcc_pkg::CFG_WIDTH-1:0]  min_digits;
  logic                           conv_valid;
  logic [lcc_pkg::BCD_WIDTH-1:0]  conv_bcd;

  // global advance: the output register is free or being emptied
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      min_digits <= lcc_pkg::MIN_DIGITS_RESET;
    end else if (cfg_we) begin
      min_digits <= cfg_wdata;
    end
  end

  // binary to decimal
  lcc_bin2bcd u_bin2bcd (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .bin_in    (card_number),
    .out_valid (conv_valid),
    .bcd_out   (conv_bcd)
  );

  // stage a: weighted digits, group sums, digit count and leading digit
  logic              a_valid;
  logic [GrpW-1:0]   a_grp      [NGrp];
  logic [GrpW-1:0]   a_grp_next [NGrp];
  logic [CountW-1:0] a_count, a_count_next;
  logic [3:0]        a_lead, a_lead_next;

  always_comb begin
    logic [3:0] d;
    logic [4:0] dbl;
    logic [3:0] w;
    for (int g = 0; g < NGrp; g++) begin
      a_grp_next[g] = '0;
    end
    a_count_next = CountW'(1);
    a_lead_next  = conv_bcd[3:0];
    for (int i = 0; i < NDig; i++) begin
      d = conv_bcd[i*4 +: 4];
      if ((i % 2) == 1) begin
        dbl = {d, 1'b0};
        w   = (dbl > 5'd9) ? 4'(dbl - 5'd9) : dbl[3:0];
      end else begin
        dbl = '0;
        w   = d;
      end
      a_grp_next[i / lcc_pkg::GROUP_SIZE] = a_grp_next[i / lcc_pkg::GROUP_SIZE] + GrpW'(w);
      if (i > 0 && d != 4'd0) begin
        a_count_next = CountW'(i + 1);
        a_lead_next  = d;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= conv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_grp   <= a_grp_next;
      a_count <= a_count_next;
      a_lead  <= a_lead_next;
    end
  end

  // stage b: total sum
  logic              b_valid;
  logic [SumW-1:0]   b_sum, b_sum_next;
  logic [CountW-1:0] b_count;
  logic [3:0]        b_lead;

  always_comb begin
    b_sum_next = '0;
    for (int g = 0; g < NGrp; g++) begin
      b_sum_next = b_sum_next + SumW'(a_grp[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_sum   <= b_sum_next;
      b_count <= a_count;
      b_lead  <= a_lead;
    end
  end

  // stage c: mod 10 test and verdict into the output register
  logic [15:0]       recip_prod;
  logic [4:0]        quot;
  logic [SumW-1:0]   quot_times10;
  logic              sum_ok;
  logic              count_ok;
  logic [1:0]        verdict_next;

  always_comb begin
    recip_prod   = 16'(b_sum) * 16'(lcc_pkg::RECIP_TEN);
    quot         = recip_prod[lcc_pkg::RECIP_SHIFT +: 5];
    quot_times10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
    sum_ok       = (b_sum == quot_times10);
    count_ok     = (b_count >= min_digits) && (b_count <= CountW'(MAX_DIGITS));
    if (!sum_ok || !count_ok) begin
      verdict_next = lcc_pkg::VERDICT_INVALID;
    end else if (b_lead == lcc_pkg::VISA_LEAD) begin
      verdict_next = lcc_pkg::VERDICT_VISA;
    end else begin
      verdict_next = lcc_pkg::VERDICT_MASTERCARD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      verdict     <= verdict_next;
      digit_count <= b_count;
      luhn_sum    <= b_sum;
    end
  end

endmodule

`default_nettype wire

// File: design/lcc_bin2bcd.sv
// ----------------------------------------------------------------------------
// lcc_bin2bcd
// Pipelined shift-and-add-3 conversion of the binary card number into packed
// decimal digits, a fixed number of input bits per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lcc_bin2bcd (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire logic [lcc_pkg::IN_WIDTH-1:0]  bin_in,
  output logic                               out_valid,
  output logic [lcc_pkg::BCD_WIDTH-1:0]      bcd_out
);

  localparam int StageCount = lcc_pkg::DD_STAGES;
  localparam int BcdW       = lcc_pkg::BCD_WIDTH;
  localparam int BinW       = lcc_pkg::IN_WIDTH;

  // add 3 to every digit of 5 or more, ahead of a left shift
  function automatic logic [BcdW-1:0] dabble_adjust(input logic [BcdW-1:0] v);
    logic [3:0]      dig;
    logic [BcdW-1:0] res;
    res = v;
    for (int i = 0; i < lcc_pkg::NUM_DIGITS; i++) begin
      dig = v[i*4 +: 4];
      if (dig >= 4'd5) begin
        res[i*4 +: 4] = dig + 4'd3;
      end
    end
    return res;
  endfunction

  logic [StageCount-1:0] stage_valid;
  logic [BcdW-1:0]       stage_bcd      [StageCount];
  logic [BinW-1:0]       stage_bin      [StageCount];
  logic [BcdW-1:0]       stage_bcd_next [StageCount];
  logic [BinW-1:0]       stage_bin_next [StageCount];
  logic [StageCount-1:0] stage_valid_next;

  for (genvar s = 0; s < StageCount; s++) begin : g_stage
    // source of this stage: the input port or the previous stage
    logic [BcdW-1:0] src_bcd;
    logic [BinW-1:0] src_bin;

    if (s == 0) begin : g_first
      assign src_bcd             = '0;
      assign src_bin             = bin_in;
      assign stage_valid_next[s] = in_valid;
    end else begin : g_rest
      assign src_bcd             = stage_bcd[s-1];
      assign src_bin             = stage_bin[s-1];
      assign stage_valid_next[s] = stage_valid[s-1];
    end

    // a few adjust-and-shift steps per stage
    always_comb begin
      logic [BcdW-1:0] b;
      logic [BinW-1:0] r;
      b = src_bcd;
      r = src_bin;
      for (int k = 0; k < lcc_pkg::BITS_PER_STAGE; k++) begin
        b = dabble_adjust(b);
        b = {b[BcdW-2:0], r[BinW-1]};
        r = {r[BinW-2:0], 1'b0};
      end
      stage_bcd_next[s] = b;
      stage_bin_next[s] = r;
    end

    // valid bits reset, payload does not
    always_ff @(posedge clk) begin
      if (rst) begin
        stage_valid[s] <= 1'b0;
      end else if (en) begin
        stage_valid[s] <= stage_valid_next[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stage_bcd[s] <= stage_bcd_next[s];
        stage_bin[s] <= stage_bin_next[s];
      end
    end
  end

  assign out_valid = stage_valid[StageCount-1];
  assign bcd_out   = stage_bcd[StageCount-1];

endmodule

`default_nettype wire
